[src/ptpm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the permutation trie prefix matcher.
// Used by ptpm_ctrl, ptpm_dpath and permutation_trie_prefix_match; no dependencies.
package ptpm_pkg;

	// Default sizing handed to the top-level parameters.
	localparam int MAX_LEN_DEF   = 10;
	localparam int MAX_NODES_DEF = 4096;

	// Fixed field widths.
	localparam int KIND_W  = 2;
	localparam int VALUE_W = 4;
	localparam int PLEN_W  = 4;

	// Configuration register map.
	localparam int            PADDR_W      = 3;
	localparam logic          REG_PERM_LEN = 1'b0;
	localparam logic [PLEN_W-1:0] PERM_LEN_RST = 4'd10;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic q_eval;
		logic inv_load;
		logic i_read;
		logic i_eval;
		logic sweep;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  last;
		logic  q_stall;
		logic  ins_end;
		logic  sweep_done;
	} sts_t;

endpackage

[src/permutation_trie_prefix_match.sv]
`timescale 1ns / 1ps
// Top level of the permutation trie prefix matcher: stream ports, register port,
// controller and datapath. Depends on ptpm_pkg, ptpm_ctrl and ptpm_dpath.
//
//   Port group      Role      Beat contents
//   s_t*            input     one permutation element with its kind
//   m_t*            output    matched prefix length and overflow flag
//   p*              config    perm_length register at byte address 0
//
// A query element makes one child table read and then one update. An insert element only
// fills the buffer, except the last of a permutation, which also walks the trie, reading
// and maybe writing the child table once per level. After reset, a clearing pass writes
// all MAX_NODES*MAX_LEN table entries, one a cycle; a clear beat sweeps the
// nodes_used*MAX_LEN entries in use the same way. No input beat is taken during a pass.
// A result waiting in the output register stalls only the next query element that ends
// a permutation.
module permutation_trie_prefix_match #(
	parameter int MAX_LEN   = ptpm_pkg::MAX_LEN_DEF,
	parameter int MAX_NODES = ptpm_pkg::MAX_NODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [3:0] value
	input  logic [ptpm_pkg::KIND_W-1:0]    s_tuser,  // [1:0] kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,  // [3:0] prefix_len, [4] overflow
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ptpm_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	logic [ptpm_pkg::PLEN_W-1:0] perm_length_q;
	logic                        reg_sel;
	ptpm_pkg::cmd_t              cmd;
	ptpm_pkg::sts_t              sts;
	logic [ptpm_pkg::PLEN_W-1:0] prefix_len;
	logic                        overflow;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == ptpm_pkg::REG_PERM_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_length_q <= ptpm_pkg::PERM_LEN_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			perm_length_q <= pwdata[ptpm_pkg::PLEN_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(32 - ptpm_pkg::PLEN_W){1'b0}}, perm_length_q} : '0;

	ptpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	ptpm_dpath #(
		.MAX_LEN   (MAX_LEN),
		.MAX_NODES (MAX_NODES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_kind        (s_tuser),
		.in_value       (s_tdata[ptpm_pkg::VALUE_W-1:0]),
		.perm_length    (perm_length_q),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_prefix_len (prefix_len),
		.out_overflow   (overflow)
	);

	assign m_tdata = {3'b000, overflow, prefix_len};

endmodule

[src/ptpm_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the permutation trie prefix matcher.
// Depends on ptpm_pkg for the command, status and kind types.
module ptpm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  ptpm_pkg::sts_t  sts,
	output logic            in_ready,
	output ptpm_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_QEVAL,
		ST_INV,
		ST_IRD,
		ST_IEVAL
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (sts.sweep_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (sts.kind)
							ptpm_pkg::KIND_INSERT: begin
								if (sts.last) state_q <= ST_INV;
							end
							ptpm_pkg::KIND_QUERY: state_q <= ST_QEVAL;
							ptpm_pkg::KIND_CLEAR: state_q <= ST_SWEEP;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_QEVAL: begin
					if (!sts.q_stall) state_q <= ST_IDLE;
				end
				ST_INV:  state_q <= ST_IRD;
				ST_IRD:  state_q <= ST_IEVAL;
				ST_IEVAL: begin
					state_q <= sts.ins_end ? ST_IDLE : ST_IRD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign cmd.accept   = (state_q == ST_IDLE) && in_valid;
	assign cmd.q_eval   = (state_q == ST_QEVAL) && !sts.q_stall;
	assign cmd.inv_load = (state_q == ST_INV);
	assign cmd.i_read   = (state_q == ST_IRD);
	assign cmd.i_eval   = (state_q == ST_IEVAL);
	assign cmd.sweep    = (state_q == ST_SWEEP);

endmodule

[src/ptpm_dpath.sv]
`timescale 1ns / 1ps
// Datapath of the permutation trie prefix matcher: element buffer, inverse,
// child table memory, walk registers, node allocator and result register.
// Depends on ptpm_pkg.
module ptpm_dpath #(
	parameter int MAX_LEN   = ptpm_pkg::MAX_LEN_DEF,
	parameter int MAX_NODES = ptpm_pkg::MAX_NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ptpm_pkg::cmd_t                cmd,
	output ptpm_pkg::sts_t                sts,
	input  logic [ptpm_pkg::KIND_W-1:0]   in_kind,
	input  logic [ptpm_pkg::VALUE_W-1:0]  in_value,
	input  logic [ptpm_pkg::PLEN_W-1:0]   perm_length,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [ptpm_pkg::PLEN_W-1:0]   out_prefix_len,
	output logic                          out_overflow
);

	localparam int VALUE_W  = ptpm_pkg::VALUE_W;
	localparam int POS_W    = ptpm_pkg::VALUE_W;
	localparam int LEN_W    = POS_W + 1;
	localparam int DEPTH    = MAX_NODES * MAX_LEN;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int NODE_W   = $clog2(MAX_NODES);
	localparam int CNT_W    = $clog2(MAX_NODES + 1);
	localparam int BUF_IW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int PLEN_W_L = ptpm_pkg::PLEN_W;

	// Child table: one entry per (node, label); zero means no child.
	logic [NODE_W-1:0] mem [DEPTH];
	logic [NODE_W-1:0] rdata_q;

	logic [VALUE_W-1:0] buf_q [MAX_LEN];
	logic [POS_W-1:0]   inv_q [MAX_LEN];
	logic [POS_W-1:0]   inv_c [MAX_LEN];

	logic [POS_W-1:0]  pos_q;
	logic [NODE_W-1:0] walk_node_q;
	logic [PLEN_W_L-1:0] matched_q;
	logic              stopped_q;
	logic              last_q;
	logic              vmiss_q;
	logic [CNT_W-1:0]  nodes_used_q;
	logic              overflow_q;
	logic [POS_W-1:0]  j_q;
	logic [NODE_W-1:0] ins_node_q;
	logic [ADDR_W-1:0] slot_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	logic [ADDR_W-1:0] sweep_last_q;
	logic              out_valid_q;
	logic [PLEN_W_L-1:0] out_len_q;
	logic              out_ovf_q;

	logic [LEN_W-1:0]  len_eff;
	logic [POS_W-1:0]  pos_c;
	logic              last_now;
	logic              is_query;
	logic              is_insert;
	logic              is_clear;
	logic              vmiss_in;
	logic [NODE_W-1:0] q_node;
	logic [ADDR_W-1:0] q_addr;
	logic [ADDR_W-1:0] i_addr;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic              child_hit;
	logic              ins_full;
	logic              alloc;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [NODE_W-1:0] wdata;
	logic              q_adv;
	logic [PLEN_W_L-1:0] matched_next;
	logic [ADDR_W:0]   clear_span;

	// A length of zero acts as one, anything past MAX_LEN as MAX_LEN.
	always_comb begin
		if (perm_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (LEN_W'(perm_length) > LEN_W'(MAX_LEN)) begin
			len_eff = LEN_W'(MAX_LEN);
		end else begin
			len_eff = LEN_W'(perm_length);
		end
	end

	assign pos_c     = ({1'b0, pos_q} >= LEN_W'(MAX_LEN)) ? POS_W'(MAX_LEN - 1) : pos_q;
	assign last_now  = ({1'b0, pos_c} + LEN_W'(1)) >= len_eff;
	assign is_query  = (in_kind == ptpm_pkg::KIND_QUERY);
	assign is_insert = (in_kind == ptpm_pkg::KIND_INSERT);
	assign is_clear  = (in_kind == ptpm_pkg::KIND_CLEAR);
	assign vmiss_in  = (LEN_W'(in_value) >= LEN_W'(MAX_LEN));

	// The query walk restarts at the root whenever a permutation begins.
	assign q_node = (pos_c == '0) ? '0 : walk_node_q;
	assign q_addr = ADDR_W'(q_node) * ADDR_W'(MAX_LEN)
		+ (vmiss_in ? '0 : ADDR_W'(in_value));
	assign i_addr = ADDR_W'(ins_node_q) * ADDR_W'(MAX_LEN)
		+ ADDR_W'(inv_q[j_q[BUF_IW-1:0]]);

	assign re    = (cmd.accept && is_query) || cmd.i_read;
	assign raddr = cmd.i_read ? i_addr : q_addr;

	// Inverse permutation; positions past the length and values of MAX_LEN or more are ignored,
	// and the later position wins on a repeated value.
	always_comb begin
		for (int v = 0; v < MAX_LEN; v++) begin
			inv_c[v] = '0;
			for (int j = 0; j < MAX_LEN; j++) begin
				if ((LEN_W'(j) < len_eff) && (buf_q[j] == VALUE_W'(v))) begin
					inv_c[v] = POS_W'(j);
				end
			end
		end
	end

	assign child_hit = (rdata_q != '0);
	assign ins_full  = (nodes_used_q == CNT_W'(MAX_NODES));
	assign alloc     = cmd.i_eval && !child_hit && !ins_full;

	assign we    = cmd.sweep || alloc;
	assign waddr = cmd.sweep ? sweep_addr_q : slot_q;
	assign wdata = cmd.sweep ? '0 : nodes_used_q[NODE_W-1:0];

	assign q_adv        = !stopped_q && !vmiss_q && child_hit;
	assign matched_next = matched_q + (q_adv ? PLEN_W_L'(1) : '0);
	assign clear_span   = (ADDR_W+1)'(nodes_used_q) * (ADDR_W+1)'(MAX_LEN) - (ADDR_W+1)'(1);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && is_insert) buf_q[pos_c[BUF_IW-1:0]] <= in_value;
		if (cmd.inv_load) begin
			for (int v = 0; v < MAX_LEN; v++) inv_q[v] <= inv_c[v];
		end
		if (cmd.i_read) slot_q <= i_addr;
		if (cmd.q_eval && last_q) begin
			out_len_q <= matched_next;
			out_ovf_q <= overflow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			walk_node_q  <= '0;
			matched_q    <= '0;
			stopped_q    <= 1'b0;
			last_q       <= 1'b0;
			vmiss_q      <= 1'b0;
			nodes_used_q <= CNT_W'(1);
			overflow_q   <= 1'b0;
			j_q          <= '0;
			ins_node_q   <= '0;
			sweep_addr_q <= '0;
			sweep_last_q <= ADDR_W'(DEPTH - 1);
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			if (cmd.accept) begin
				if (is_clear) begin
					pos_q        <= '0;
					walk_node_q  <= '0;
					matched_q    <= '0;
					stopped_q    <= 1'b0;
					nodes_used_q <= CNT_W'(1);
					overflow_q   <= 1'b0;
					sweep_addr_q <= '0;
					sweep_last_q <= clear_span[ADDR_W-1:0];
				end else if (is_insert || is_query) begin
					pos_q <= last_now ? '0 : pos_c + POS_W'(1);
				end
				if (is_query) begin
					walk_node_q <= q_node;
					if (pos_c == '0) begin
						matched_q <= '0;
						stopped_q <= 1'b0;
					end
					last_q  <= last_now;
					vmiss_q <= vmiss_in;
				end
			end

			if (cmd.q_eval) begin
				if (last_q) begin
					out_valid_q <= 1'b1;
					walk_node_q <= '0;
					matched_q   <= '0;
					stopped_q   <= 1'b0;
				end else if (!stopped_q) begin
					if (q_adv) begin
						walk_node_q <= rdata_q;
						matched_q   <= matched_next;
					end else begin
						stopped_q <= 1'b1;
					end
				end
			end

			if (cmd.inv_load) begin
				j_q        <= '0;
				ins_node_q <= '0;
			end

			if (cmd.i_eval) begin
				j_q <= j_q + POS_W'(1);
				if (child_hit) begin
					ins_node_q <= rdata_q;
				end else if (ins_full) begin
					overflow_q <= 1'b1;
				end else begin
					ins_node_q   <= nodes_used_q[NODE_W-1:0];
					nodes_used_q <= nodes_used_q + CNT_W'(1);
				end
			end

			if (cmd.sweep) sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
		end
	end

	assign sts.kind       = ptpm_pkg::kind_t'(in_kind);
	assign sts.last       = last_now;
	assign sts.q_stall    = last_q && out_valid_q && !out_ready;
	assign sts.ins_end    = (!child_hit && ins_full)
		|| (({1'b0, j_q} + LEN_W'(1)) >= len_eff);
	assign sts.sweep_done = (sweep_addr_q == sweep_last_q);

	assign out_valid      = out_valid_q;
	assign out_prefix_len = out_len_q;
	assign out_overflow   = out_ovf_q;

endmodule

[tb/sv/permutation_trie_prefix_match_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for permutation_trie_prefix_match: random and directed element beats,
// a trie tracker that predicts each prefix-length result, and register writes between phases.
// Depends on ptpm_pkg and the RTL of permutation_trie_prefix_match.

typedef struct packed {
	logic [3:0] prefix_len;
	logic       overflow;
} match_t;

// Tracks the trie as the block should hold it and queues the results it should emit.
class trie_tracker;
	localparam int LMAX  = ptpm_pkg::MAX_LEN_DEF;
	localparam int NODES = ptpm_pkg::MAX_NODES_DEF;

	int unsigned       child[NODES*LMAX];
	int unsigned       nodes_used;
	logic [3:0]        elem_buf[LMAX];
	logic [3:0]        plen;
	int unsigned       pos;
	int unsigned       walk;
	int unsigned       matched;
	bit                stopped;
	bit                ovf;
	match_t            pending[$];
	logic [LMAX*4-1:0] paths[$];
	int                errors;
	int                settle;

	function new();
		plen = ptpm_pkg::PERM_LEN_RST;
		foreach (elem_buf[i]) elem_buf[i] = 4'd0;
		errors = 0;
		settle = 0;
		pos = 0;
		wipe();
		restart();
	endfunction

	function int unsigned eff_len();
		if (plen < 1) return 1;
		if (plen > LMAX) return LMAX;
		return plen;
	endfunction

	function void restart();
		walk = 0;
		matched = 0;
		stopped = 0;
	endfunction

	function void wipe();
		foreach (child[i]) child[i] = 0;
		nodes_used = 1;
		ovf = 0;
		paths.delete();
	endfunction

	// Insert the inverse of the buffered permutation, allocating missing nodes.
	function void grow(int unsigned len);
		int unsigned       inv[LMAX];
		logic [LMAX*4-1:0] p;
		int unsigned       node;
		int unsigned       slot;
		int unsigned       j;
		foreach (inv[i]) inv[i] = 0;
		for (j = 0; j < len; j++)
			if (elem_buf[j] < len) inv[elem_buf[j]] = j;
		p = '0;
		for (j = 0; j < LMAX; j++) p[j*4 +: 4] = 4'(inv[j]);
		paths = {paths, p};
		if (paths.size() > 64) void'(paths.pop_front());
		node = 0;
		for (j = 0; j < len; j++) begin
			slot = node*LMAX + inv[j];
			if (child[slot] == 0) begin
				if (nodes_used >= NODES) begin
					ovf = 1;
					return;
				end
				child[slot] = nodes_used;
				nodes_used++;
			end
			node = child[slot];
		end
	endfunction

	function void note_beat(logic [1:0] k, logic [3:0] v);
		int unsigned len;
		int unsigned next_node;
		bit          last;
		match_t      res;
		len = eff_len();
		settle = 2*LMAX + 8;
		if (k == ptpm_pkg::KIND_CLEAR) begin
			// The clear sweep covers every node in use, one table entry a cycle.
			settle = nodes_used*LMAX + 16;
			wipe();
			pos = 0;
			restart();
			return;
		end
		if (k != ptpm_pkg::KIND_INSERT && k != ptpm_pkg::KIND_QUERY) return;
		if (pos >= LMAX) pos = LMAX - 1;
		last = (pos + 1 >= len);
		if (k == ptpm_pkg::KIND_INSERT) begin
			elem_buf[pos] = v;
			if (last) grow(len);
			pos = last ? 0 : pos + 1;
			return;
		end
		if (pos == 0) restart();
		if (!stopped) begin
			next_node = (v < LMAX) ? child[walk*LMAX + v] : 0;
			if (next_node != 0) begin
				walk = next_node;
				matched++;
			end else begin
				stopped = 1;
			end
		end
		if (!last) begin
			pos++;
			return;
		end
		res.prefix_len = 4'(matched);
		res.overflow   = ovf;
		pending = {pending, res};
		pos = 0;
		restart();
	endfunction

	task report(string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task check_result(logic [7:0] d);
		match_t want;
		if (pending.size() == 0) begin
			report($sformatf("result beat 0x%02h with no query outstanding", d));
			return;
		end
		want = pending.pop_front();
		if (d[3:0] !== want.prefix_len)
			report($sformatf("prefix_len %0d, expected %0d", d[3:0], want.prefix_len));
		if (d[4] !== want.overflow)
			report($sformatf("overflow %0b, expected %0b", d[4], want.overflow));
	endtask
endclass

module permutation_trie_prefix_match_tb;

	localparam int          LMAX        = ptpm_pkg::MAX_LEN_DEF;
	localparam int          CYCLE_LIMIT = 3_000_000;
	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam logic [ptpm_pkg::PADDR_W-1:0] LEN_ADDR = {ptpm_pkg::REG_PERM_LEN, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [3:0] value
	logic [1:0]  s_tuser;   // [1:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [3:0] prefix_len, [4] overflow
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ptpm_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	trie_tracker sb;
	int          cycles;
	int          hold_off;
	int          beats_sent;
	bit          tx_steady;
	bit          rx_steady;

	permutation_trie_prefix_match i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : result_sink
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (!rx_steady && $urandom_range(99) < 30) begin
				stall = pick_gap();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input logic [1:0] k, input logic [3:0] v);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {4'b0000, v};
		do @(posedge clk); while (!s_tready);
		sb.note_beat(k, v);
		if (k != KIND_UNUSED) beats_sent++;
		@(negedge clk);
	endtask

	// Wait until every result is in and the block has had time to finish its last beat.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (sb.settle) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_length(input logic [3:0] len);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LEN_ADDR;
		pwdata  <= {28'd0, len};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.plen = len;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {28'd0, len})
			sb.report($sformatf("perm_length reads 0x%08h, wrote %0d", prdata, len));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_perm(input logic [1:0] k, input int unsigned len, input bit wild);
		logic [3:0] p[LMAX];
		logic [3:0] t;
		int         j;
		int         r;
		for (j = 0; j < LMAX; j++) p[j] = 4'(j);
		for (j = len - 1; j > 0; j--) begin
			r = $urandom_range(j);
			t = p[j];
			p[j] = p[r];
			p[r] = t;
		end
		for (j = 0; j < len; j++)
			send_beat(k, wild ? 4'($urandom_range(15)) : p[j]);
	endtask

	// Walks a stored inverse, now and then with one element changed.
	task automatic send_known_query(input int unsigned len);
		logic [LMAX*4-1:0] p;
		int                bad;
		int                j;
		p = sb.paths[$urandom_range(sb.paths.size() - 1)];
		bad = ($urandom_range(99) < 30) ? $urandom_range(len - 1) : -1;
		for (j = 0; j < len; j++)
			send_beat(ptpm_pkg::KIND_QUERY, (j == bad) ? 4'($urandom_range(15)) : p[j*4 +: 4]);
	endtask

	task automatic send_sequence();
		int unsigned len;
		int          r;
		len = sb.eff_len();
		r = $urandom_range(99);
		if (r < 3) begin
			send_beat(ptpm_pkg::KIND_CLEAR, 4'($urandom_range(15)));
		end else if (r < 6) begin
			send_beat(KIND_UNUSED, 4'($urandom_range(15)));
		end else if (r < 12) begin
			send_beat(2'($urandom_range(1)), 4'($urandom_range(15)));
		end else if (r < 50) begin
			send_perm(ptpm_pkg::KIND_INSERT, len, $urandom_range(99) < 20);
		end else if (sb.paths.size() != 0 && $urandom_range(99) < 70) begin
			send_known_query(len);
		end else begin
			send_perm(ptpm_pkg::KIND_QUERY, len, $urandom_range(99) < 30);
		end
	endtask

	initial begin : stimulus
		logic [3:0]        lens[16];
		logic [LMAX*4-1:0] p;
		int                ph;
		int                j;
		int                target;
		int                guard;

		lens = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd3, 4'd2, 4'd11, 4'd5,
		         4'd7, 4'd12, 4'd4, 4'd13, 4'd6, 4'd14, 4'd8, 4'd9};
		sb = new();
		cycles = 0;
		hold_off = 0;
		beats_sent = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'd0;
		s_tuser  = 2'd0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = 32'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Full insert at the reset length first, so every buffer entry holds a value
		// before any later insert can read it.
		for (j = 0; j < LMAX; j++) send_beat(ptpm_pkg::KIND_INSERT, 4'((3*j + 1) % LMAX));
		p = sb.paths[sb.paths.size() - 1];
		for (j = 0; j < LMAX; j++) send_beat(ptpm_pkg::KIND_QUERY, p[j*4 +: 4]);
		send_beat(KIND_UNUSED, 4'hF);
		send_beat(ptpm_pkg::KIND_CLEAR, 4'h0);
		quiesce();

		for (ph = 0; ph < 16; ph++) begin
			set_length(lens[ph]);
			tx_steady = ($urandom_range(3) == 0);
			rx_steady = ($urandom_range(3) == 0);
			target = beats_sent + 30;
			if (lens[ph] == 4'd2) begin
				// Long receiver hold-off while queries keep coming, to back up the input.
				hold_off = 400;
				send_perm(ptpm_pkg::KIND_INSERT, 2, 1'b0);
				while (beats_sent < target) send_perm(ptpm_pkg::KIND_QUERY, 2, 1'b0);
			end
			while (beats_sent < target) send_sequence();
			// Leave some phases mid-permutation so the length changes under a partial one.
			if ($urandom_range(1) == 1)
				repeat ($urandom_range(1, 3))
					send_beat(2'($urandom_range(1)), 4'($urandom_range(15)));
			quiesce();
		end

		// Rebuild a small trie at full length, query it, then check that a clear empties it.
		set_length(4'd10);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		send_beat(ptpm_pkg::KIND_CLEAR, 4'h5);
		guard = 0;
		while (guard < 4) begin
			send_perm(ptpm_pkg::KIND_INSERT, LMAX, 1'b0);
			guard++;
		end
		repeat (4) send_known_query(LMAX);
		repeat (2) send_perm(ptpm_pkg::KIND_QUERY, LMAX, 1'b0);
		quiesce();
		send_beat(ptpm_pkg::KIND_CLEAR, 4'hA);
		repeat (2) send_perm(ptpm_pkg::KIND_QUERY, LMAX, 1'b0);
		quiesce();

		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
src/ptpm_pkg.sv
src/ptpm_ctrl.sv
src/ptpm_dpath.sv
src/permutation_trie_prefix_match.sv
tb/sv/permutation_trie_prefix_match_tb.sv
